[hw/rtl/ppe_pkg.sv]
// Shared types, constants and helpers for the particle pool engine.
// Used by every RTL module of the block but ppe_ram, and by its checker. No dependencies.
`default_nettype none

package ppe_pkg;

  localparam int          PPE_SLOTS  = 1024;
  localparam logic [31:0] SEED_RESET = 32'd12345678;
  localparam logic [31:0] LFSR_MASK  = 32'h80200003;

  typedef enum logic [1:0] {
    OP_SPAWN   = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_READ    = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [9:0]  slot_index;
    logic [10:0] spawn_count;
    logic [15:0] time_step;
    logic [15:0] life_time;
    logic [31:0] position_xy;
    logic [31:0] velocity_low_xy;
    logic [31:0] velocity_high_xy;
    logic [31:0] size_low_xy;
    logic [31:0] size_high_xy;
    logic [31:0] birth_rgba;
    logic [31:0] death_rgba;
  } in_item_t;

  typedef struct packed {
    logic        slot_active;
    logic [31:0] slot_position_xy;
    logic [31:0] slot_size_xy;
    logic [31:0] slot_colour_rgba;
    logic [10:0] alive_count;
    logic [10:0] died_count;
  } out_item_t;

  // One slot of the particle store, kept in a single RAM word.
  typedef struct packed {
    logic            live;
    logic [15:0]     age;
    logic [15:0]     life;
    logic [31:0]     pos_x;      // signed, units of 2^-14 px
    logic [31:0]     pos_y;
    logic [31:0]     vel;        // signed Q2.14 px per time unit per half
    logic [31:0]     size;
    logic [31:0]     start_col;
    logic [3:0][8:0] delta;      // death minus birth per channel
    logic [31:0]     shown;
  } slot_word_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_SP_RD,
    ST_SP_DRAW,
    ST_SP_WR,
    ST_ADV_RD,
    ST_ADV_CHK,
    ST_ADV_NUM,
    ST_ADV_DIV,
    ST_ADV_WR,
    ST_FIN
  } ppe_state_t;

  typedef struct packed {
    logic       start;
    logic       clr_wr;
    logic       draw_en;
    logic [1:0] draw_sel;
    logic       sp_wr;
    logic       adv_load;
    logic       num_load;
    logic       div_step;
    logic       adv_wr;
    logic       res_load;
  } ppe_cmd_t;

  typedef struct packed {
    op_t         op;
    logic [10:0] spawn_count;
    logic        slot_live;
    logic        out_stall;
  } ppe_stat_t;

  // One step of the right-shifting Galois LFSR.
  function automatic logic [31:0] lfsr_step(input logic [31:0] s);
    logic [31:0] n;
    n = {1'b0, s[31:1]};
    if (s[0]) begin
      n = n ^ LFSR_MASK;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/particle_pool_engine.sv]
// Particle pool engine: ring store of SLOTS particles with spawn, advance, read.
// Spawn reads, draws and writes each particle in turn; advance reads and checks
//   each slot, and for a live slot also runs the serial colour divider.
// Throughput: one transaction at a time, set by the single store port that
//   the advance walk visits slot by slot.
// Reset: synchronous, active low; afterwards a clearing sweep of all SLOTS slots
//   zeroes the store, with in_ready low. Seed writes are taken except in reset.
`default_nettype none

module particle_pool_engine import ppe_pkg::*; #(
  parameter int SLOTS = PPE_SLOTS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input transactions
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  // result transactions
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  // seed register
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_data
);

  localparam int SW = $clog2(SLOTS);

  ppe_cmd_t      cmd;
  ppe_stat_t     stat;
  logic [SW-1:0] slot_addr;
  logic          in_accept;

  // Accept only in idle; the item is held in the datapath until the next accept.
  assign in_accept = in_valid & in_ready;

  // Sequencer: drives the clear sweep, the per-particle spawn steps and the
  // slot-by-slot advance walk; holds the write pointer.
  ppe_ctrl #(
    .SLOTS(SLOTS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd),
    .slot_addr(slot_addr)
  );

  // Datapath: store, LFSR, move/age/retire, colour divider and result register.
  ppe_datapath #(
    .SLOTS(SLOTS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .in_accept(in_accept),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .slot_addr(slot_addr),
    .stat     (stat),
    .out_valid(out_valid),
    .out_data (out_data),
    .out_ready(out_ready)
  );

endmodule

`default_nettype wire

[hw/rtl/ppe_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ppe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/ppe_ctrl.sv]
// Sequencer of the particle pool engine: clear sweep, spawn, advance walk, result.
// Depends on ppe_pkg.
`default_nettype none

module ppe_ctrl import ppe_pkg::*; #(
  parameter int SLOTS = PPE_SLOTS,
  localparam int SW = $clog2(SLOTS)
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire ppe_stat_t stat,
  output logic           in_ready,
  output ppe_cmd_t       cmd,
  output logic [SW-1:0]  slot_addr
);

  localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

  ppe_state_t  state_r, state_nxt;
  logic [SW-1:0] idx_r, idx_nxt;
  logic [SW-1:0] ptr_r, ptr_nxt;
  logic [10:0]   rem_r, rem_nxt;
  logic [2:0]    sub_r, sub_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      idx_r   <= '0;
      ptr_r   <= '0;
      rem_r   <= '0;
      sub_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      ptr_r   <= ptr_nxt;
      rem_r   <= rem_nxt;
      sub_r   <= sub_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    ptr_nxt      = ptr_r;
    rem_nxt      = rem_r;
    sub_nxt      = sub_r;
    cmd          = '0;
    cmd.draw_sel = sub_r[1:0];
    in_ready     = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (idx_r == LAST) begin
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cmd.start = 1'b1;
        case (stat.op)
          OP_SPAWN: begin
            if (stat.spawn_count == '0) begin
              state_nxt = ST_FIN;
            end else begin
              rem_nxt   = stat.spawn_count;
              state_nxt = ST_SP_RD;
            end
          end
          OP_ADVANCE: begin
            idx_nxt   = '0;
            state_nxt = ST_ADV_RD;
          end
          default: state_nxt = ST_FIN;
        endcase
      end
      ST_SP_RD: begin
        sub_nxt   = '0;
        state_nxt = ST_SP_DRAW;
      end
      ST_SP_DRAW: begin
        cmd.draw_en = 1'b1;
        if (sub_r == 3'd3) begin
          state_nxt = ST_SP_WR;
        end else begin
          sub_nxt = sub_r + 1'b1;
        end
      end
      ST_SP_WR: begin
        cmd.sp_wr = 1'b1;
        ptr_nxt   = (ptr_r == LAST) ? '0 : ptr_r + 1'b1;
        rem_nxt   = rem_r - 1'b1;
        state_nxt = (rem_r == 11'd1) ? ST_FIN : ST_SP_RD;
      end
      ST_ADV_RD: begin
        state_nxt = ST_ADV_CHK;
      end
      ST_ADV_CHK: begin
        if (stat.slot_live) begin
          cmd.adv_load = 1'b1;
          state_nxt    = ST_ADV_NUM;
        end else if (idx_r == LAST) begin
          state_nxt = ST_FIN;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_ADV_RD;
        end
      end
      ST_ADV_NUM: begin
        cmd.num_load = 1'b1;
        sub_nxt      = '0;
        state_nxt    = ST_ADV_DIV;
      end
      ST_ADV_DIV: begin
        cmd.div_step = 1'b1;
        if (sub_r == 3'd7) begin
          state_nxt = ST_ADV_WR;
        end else begin
          sub_nxt = sub_r + 1'b1;
        end
      end
      ST_ADV_WR: begin
        cmd.adv_wr = 1'b1;
        if (idx_r == LAST) begin
          state_nxt = ST_FIN;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_ADV_RD;
        end
      end
      ST_FIN: begin
        if (!stat.out_stall) begin
          cmd.res_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign slot_addr = (state_r == ST_SP_RD || state_r == ST_SP_DRAW || state_r == ST_SP_WR)
                     ? ptr_r : idx_r;

endmodule

`default_nettype wire

[hw/rtl/ppe_datapath.sv]
// Datapath of the particle pool engine: slot store, LFSR draws, advance
// arithmetic with serial colour divider, counters and result register.
// Depends on ppe_pkg and ppe_ram.
`default_nettype none

module ppe_datapath import ppe_pkg::*; #(
  parameter int SLOTS = PPE_SLOTS,
  localparam int SW = $clog2(SLOTS),
  localparam int CW = $clog2(SLOTS + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire in_item_t      in_data,
  input  wire logic          in_accept,
  input  wire logic          cfg_we,
  input  wire logic [31:0]   cfg_data,
  input  wire ppe_cmd_t      cmd,
  input  wire logic [SW-1:0] slot_addr,
  output ppe_stat_t          stat,
  output logic               out_valid,
  output out_item_t          out_data,
  input  wire logic          out_ready
);

  localparam int IW = (SW > 10) ? SW : 10;

  in_item_t    item_r;
  logic [31:0] lfsr_r;
  logic [15:0] draws_r [4];
  logic [CW-1:0] live_r, died_r, live_nxt;
  logic        out_valid_r;
  out_item_t   out_r;

  // advance working registers
  slot_word_t  w_r;
  logic [15:0] a_r;
  logic [23:0] rem_r [4];
  logic [7:0]  q_r [4];
  logic [7:0]  d_r [4];
  logic [22:0] den_r;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r <= in_data;
    end
  end

  // slot store
  logic [SW-1:0] rd_addr;
  logic [IW-1:0] idx_ext;
  logic          idx_ok;
  logic          ram_we;
  slot_word_t    wr_word, sp_word, adv_word, rd;
  logic [$bits(slot_word_t)-1:0] rd_bits;

  assign idx_ext = IW'(item_r.slot_index);
  assign idx_ok  = (32'(item_r.slot_index) < 32'(SLOTS));
  assign rd_addr = (item_r.op == OP_READ) ? idx_ext[SW-1:0] : slot_addr;
  assign ram_we  = cmd.clr_wr | cmd.sp_wr | cmd.adv_wr;
  assign rd      = slot_word_t'(rd_bits);

  always_comb begin
    if (cmd.clr_wr) begin
      wr_word = '0;
    end else if (cmd.sp_wr) begin
      wr_word = sp_word;
    end else begin
      wr_word = adv_word;
    end
  end

  ppe_ram #(
    .WIDTH($bits(slot_word_t)),
    .DEPTH(SLOTS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(slot_addr),
    .wdata(wr_word),
    .raddr(rd_addr),
    .rdata(rd_bits)
  );

  // random draw: lo + floor((hi - lo) * r / 2^32)
  logic [31:0]        lfsr_new;
  logic [15:0]        lo, hi, draw_val;
  logic               sgn;
  logic signed [16:0] diff_s;
  logic signed [49:0] prod;

  assign lfsr_new = lfsr_step(lfsr_r);

  always_comb begin
    case (cmd.draw_sel)
      2'd0: begin
        lo = item_r.velocity_low_xy[15:0];  hi = item_r.velocity_high_xy[15:0];  sgn = 1'b1;
      end
      2'd1: begin
        lo = item_r.velocity_low_xy[31:16]; hi = item_r.velocity_high_xy[31:16]; sgn = 1'b1;
      end
      2'd2: begin
        lo = item_r.size_low_xy[15:0];      hi = item_r.size_high_xy[15:0];      sgn = 1'b0;
      end
      default: begin
        lo = item_r.size_low_xy[31:16];     hi = item_r.size_high_xy[31:16];     sgn = 1'b0;
      end
    endcase
    diff_s   = $signed({sgn & hi[15], hi}) - $signed({sgn & lo[15], lo});
    prod     = diff_s * $signed({1'b0, lfsr_new});
    draw_val = lo + prod[47:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= SEED_RESET;
    end else if (cfg_we) begin
      lfsr_r <= cfg_data;
    end else if (cmd.draw_en) begin
      lfsr_r <= lfsr_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.draw_en) begin
      draws_r[cmd.draw_sel] <= draw_val;
    end
  end

  // spawn word
  always_comb begin
    sp_word           = '0;
    sp_word.live      = 1'b1;
    sp_word.life      = item_r.life_time;
    sp_word.pos_x     = {{2{item_r.position_xy[15]}}, item_r.position_xy[15:0], 14'd0};
    sp_word.pos_y     = {{2{item_r.position_xy[31]}}, item_r.position_xy[31:16], 14'd0};
    sp_word.vel       = {draws_r[1], draws_r[0]};
    sp_word.size      = {draws_r[3], draws_r[2]};
    sp_word.start_col = item_r.birth_rgba;
    sp_word.shown     = item_r.birth_rgba;
    for (int ch = 0; ch < 4; ch++) begin
      sp_word.delta[ch] = {1'b0, item_r.death_rgba[8*ch +: 8]}
                        - {1'b0, item_r.birth_rgba[8*ch +: 8]};
    end
  end

  // advance: age, retire, move
  logic [16:0]        age_sum;
  logic [15:0]        age_n;
  logic               retire;
  logic signed [32:0] mv_x, mv_y;
  slot_word_t         w_nxt;

  always_comb begin
    age_sum     = {1'b0, rd.age} + {1'b0, item_r.time_step};
    age_n       = age_sum[16] ? 16'hFFFF : age_sum[15:0];
    retire      = (age_n >= rd.life);
    mv_x        = $signed(rd.vel[15:0])  * $signed({1'b0, item_r.time_step});
    mv_y        = $signed(rd.vel[31:16]) * $signed({1'b0, item_r.time_step});
    w_nxt       = rd;
    w_nxt.live  = ~retire;
    w_nxt.age   = age_n;
    w_nxt.pos_x = rd.pos_x + mv_x[31:0];
    w_nxt.pos_y = rd.pos_y + mv_y[31:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.adv_load) begin
      w_r <= w_nxt;
      a_r <= (age_n < rd.life) ? age_n : rd.life;
    end
  end

  // colour blend: (b*(L-a) + d*a) / L by restoring division, one bit a step
  logic [7:0]  b_c [4];
  logic [7:0]  d_c [4];
  logic [15:0] l_minus_a;
  logic [24:0] trial [4];

  always_comb begin
    l_minus_a = w_r.life - a_r;
    for (int ch = 0; ch < 4; ch++) begin
      b_c[ch]   = w_r.start_col[8*ch +: 8];
      d_c[ch]   = b_c[ch] + w_r.delta[ch][7:0];
      trial[ch] = {1'b0, rem_r[ch]} - {2'b00, den_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.num_load) begin
      den_r <= {w_r.life, 7'd0};
      for (int ch = 0; ch < 4; ch++) begin
        rem_r[ch] <= 24'(b_c[ch]) * 24'(l_minus_a) + 24'(d_c[ch]) * 24'(a_r);
        q_r[ch]   <= '0;
        d_r[ch]   <= d_c[ch];
      end
    end else if (cmd.div_step) begin
      den_r <= {1'b0, den_r[22:1]};
      for (int ch = 0; ch < 4; ch++) begin
        if (!trial[ch][24]) begin
          rem_r[ch] <= trial[ch][23:0];
          q_r[ch]   <= {q_r[ch][6:0], 1'b1};
        end else begin
          q_r[ch] <= {q_r[ch][6:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    adv_word = w_r;
    for (int ch = 0; ch < 4; ch++) begin
      adv_word.shown[8*ch +: 8] = (w_r.life == '0) ? d_r[ch] : q_r[ch];
    end
  end

  // counters
  assign live_nxt = (item_r.op == OP_ADVANCE) ? live_r - died_r : live_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
      died_r <= '0;
    end else begin
      if (cmd.start) begin
        died_r <= '0;
      end else if (cmd.adv_load && retire) begin
        died_r <= died_r + 1'b1;
      end
      if (cmd.sp_wr && !rd.live) begin
        live_r <= live_r + 1'b1;
      end else if (cmd.res_load) begin
        live_r <= live_nxt;
      end
    end
  end

  // result register
  logic active;
  assign active = (item_r.op == OP_READ) && idx_ok && rd.live;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_r.slot_active      <= active;
      out_r.slot_position_xy <= active ? {rd.pos_y[29:14], rd.pos_x[29:14]} : '0;
      out_r.slot_size_xy     <= active ? rd.size : '0;
      out_r.slot_colour_rgba <= active ? rd.shown : '0;
      out_r.alive_count      <= 11'(live_nxt);
      out_r.died_count       <= (item_r.op == OP_ADVANCE) ? 11'(died_r) : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data         = out_r;
  assign stat.op          = item_r.op;
  assign stat.spawn_count = item_r.spawn_count;
  assign stat.slot_live   = rd.live;
  assign stat.out_stall   = out_valid_r & ~out_ready;

endmodule

`default_nettype wire

[hw/rtl/ppe_checker.sv]
// Port-level checks for the particle pool engine, bound to its top level.
// Depends on ppe_pkg and particle_pool_engine.
`default_nettype none

module ppe_checker import ppe_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire out_item_t   out_data
);

  // one transaction in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a transaction is in flight");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // an inactive result (free slot, or not a read) reports zero slot fields
  a_free_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.slot_active |->
      out_data.slot_position_xy == '0 && out_data.slot_size_xy == '0 &&
      out_data.slot_colour_rgba == '0)
    else $error("free slot with nonzero fields");

  // a read of a live slot never reports retirements
  a_read_no_died: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.slot_active |-> out_data.died_count == '0)
    else $error("read reported retired slots");

endmodule

bind particle_pool_engine ppe_checker u_ppe_checker (.*);

`default_nettype wire

[tb/sv/tb_particle_pool_engine.sv]
// Self-checking testbench for particle_pool_engine: spawn, advance and read
// transactions checked against a behavioral particle store kept in the bench.
// Depends on ppe_pkg and the particle_pool_engine RTL.
`timescale 1ns / 100ps

module tb_particle_pool_engine;
  import ppe_pkg::*;

  localparam int N_SLOTS = 1024;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic [31:0] cfg_data = '0;

  particle_pool_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Behavioral particle store, updated as each input transaction is accepted.
  logic        p_live  [N_SLOTS];
  logic [15:0] p_age   [N_SLOTS];
  logic [15:0] p_life  [N_SLOTS];
  logic [31:0] p_pos_x [N_SLOTS];
  logic [31:0] p_pos_y [N_SLOTS];
  logic [31:0] p_vel   [N_SLOTS];
  logic [31:0] p_size  [N_SLOTS];
  logic [31:0] p_birth [N_SLOTS];
  logic [31:0] p_death [N_SLOTS];
  logic [31:0] p_shown [N_SLOTS];
  int          p_wr_ptr = 0;
  int          p_alive = 0;
  logic [31:0] p_rng = SEED_RESET;

  in_item_t  pending_items [$];
  out_item_t expected_results [$];
  int        n_errors = 0;
  bit        in_taken = 1'b0;
  bit        quiet = 1'b0;      // no idling on either side
  int        gen_ptr = 0;       // write pointer as seen while generating stimulus

  function automatic int sx16(logic [15:0] v);
    return int'($signed(v));
  endfunction

  // Advance the generator, then place a value between the bounds.
  function automatic logic [15:0] draw_between(logic [15:0] lo_raw, logic [15:0] hi_raw,
                                               bit is_signed);
    longint lo, hi, prod;
    p_rng = {1'b0, p_rng[31:1]} ^ (p_rng[0] ? LFSR_MASK : 32'h0);
    lo = is_signed ? sx16(lo_raw) : longint'(lo_raw);
    hi = is_signed ? sx16(hi_raw) : longint'(hi_raw);
    prod = (hi - lo) * longint'({32'h0, p_rng});
    return 16'(lo + (prod >>> 32));
  endfunction

  function automatic logic [31:0] blend_colour(int s);
    int life, a, b, d, c;
    logic [31:0] res;
    life = p_life[s];
    a = (p_age[s] < life) ? int'(p_age[s]) : life;
    res = '0;
    for (int ch = 0; ch < 4; ch++) begin
      b = p_birth[s][8*ch +: 8];
      d = p_death[s][8*ch +: 8];
      c = (life == 0) ? d : (b * (life - a) + d * a) / life;
      res[8*ch +: 8] = c[7:0];
    end
    return res;
  endfunction

  function automatic out_item_t predict_pool_op(in_item_t it);
    out_item_t r;
    int died;
    int s;
    int na;
    r = '0;
    died = 0;
    case (it.op)
      OP_SPAWN: begin
        for (int i = 0; i < it.spawn_count; i++) begin
          s = p_wr_ptr;
          p_wr_ptr = (p_wr_ptr + 1 >= N_SLOTS) ? 0 : p_wr_ptr + 1;
          if (!p_live[s]) begin
            p_live[s] = 1'b1;
            p_alive++;
          end
          p_age[s]   = '0;
          p_life[s]  = it.life_time;
          p_pos_x[s] = 32'(sx16(it.position_xy[15:0])) << 14;
          p_pos_y[s] = 32'(sx16(it.position_xy[31:16])) << 14;
          p_vel[s][15:0]   = draw_between(it.velocity_low_xy[15:0],
                                          it.velocity_high_xy[15:0], 1'b1);
          p_vel[s][31:16]  = draw_between(it.velocity_low_xy[31:16],
                                          it.velocity_high_xy[31:16], 1'b1);
          p_size[s][15:0]  = draw_between(it.size_low_xy[15:0], it.size_high_xy[15:0], 1'b0);
          p_size[s][31:16] = draw_between(it.size_low_xy[31:16], it.size_high_xy[31:16], 1'b0);
          p_birth[s] = it.birth_rgba;
          p_death[s] = it.death_rgba;
          p_shown[s] = it.birth_rgba;
        end
      end
      OP_ADVANCE: begin
        for (int i = 0; i < N_SLOTS; i++) begin
          if (p_live[i]) begin
            na = int'(p_age[i]) + int'(it.time_step);
            p_age[i] = (na > 65535) ? 16'hFFFF : 16'(na);
            if (p_age[i] >= p_life[i]) begin
              p_live[i] = 1'b0;
              died++;
            end
            p_pos_x[i] += 32'(sx16(p_vel[i][15:0]) * int'(it.time_step));
            p_pos_y[i] += 32'(sx16(p_vel[i][31:16]) * int'(it.time_step));
            p_shown[i] = blend_colour(i);
          end
        end
        p_alive -= died;
      end
      OP_READ: begin
        if (p_live[it.slot_index]) begin
          r.slot_active      = 1'b1;
          r.slot_position_xy = {p_pos_y[it.slot_index][29:14], p_pos_x[it.slot_index][29:14]};
          r.slot_size_xy     = p_size[it.slot_index];
          r.slot_colour_rgba = p_shown[it.slot_index];
        end
      end
      default: ;
    endcase
    r.alive_count = 11'(p_alive);
    r.died_count  = 11'(died);
    return r;
  endfunction

  // Monitor: predict on each accepted input, check each accepted result.
  always @(posedge clk) begin
    out_item_t exp_r;
    in_taken <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready)
      expected_results.push_back(predict_pool_op(in_data));
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result with no expectation pending: %h", out_data);
        n_errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_data.slot_active !== exp_r.slot_active) begin
          $error("slot_active exp %h got %h", exp_r.slot_active, out_data.slot_active);
          n_errors++;
        end
        if (out_data.slot_position_xy !== exp_r.slot_position_xy) begin
          $error("slot_position_xy exp %h got %h", exp_r.slot_position_xy,
                 out_data.slot_position_xy);
          n_errors++;
        end
        if (out_data.slot_size_xy !== exp_r.slot_size_xy) begin
          $error("slot_size_xy exp %h got %h", exp_r.slot_size_xy, out_data.slot_size_xy);
          n_errors++;
        end
        if (out_data.slot_colour_rgba !== exp_r.slot_colour_rgba) begin
          $error("slot_colour_rgba exp %h got %h", exp_r.slot_colour_rgba,
                 out_data.slot_colour_rgba);
          n_errors++;
        end
        if (out_data.alive_count !== exp_r.alive_count) begin
          $error("alive_count exp %0d got %0d", exp_r.alive_count, out_data.alive_count);
          n_errors++;
        end
        if (out_data.died_count !== exp_r.died_count) begin
          $error("died_count exp %0d got %0d", exp_r.died_count, out_data.died_count);
          n_errors++;
        end
      end
    end
  end

  // Driver: hold each transaction until accepted, then advance the queue,
  // sometimes inserting an idle burst.
  int send_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_taken) begin
        // hold
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0)
          send_gap = $urandom_range(1, 13);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result back-pressure in random bursts.
  int stall_left = 0;
  always @(negedge clk) begin
    if (!rst_n || quiet) begin
      out_ready <= rst_n;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 12);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic in_item_t mk_item(op_t op);
    in_item_t it;
    it = '0;
    it.op = op;
    it.slot_index       = 10'($urandom);
    it.spawn_count      = 11'($urandom_range(0, 16));
    it.time_step        = 16'($urandom_range(0, 400));
    it.life_time        = 16'($urandom_range(100, 3000));
    it.position_xy      = $urandom;
    it.velocity_low_xy  = $urandom;
    it.velocity_high_xy = $urandom;
    it.size_low_xy      = $urandom;
    it.size_high_xy     = $urandom;
    it.birth_rgba       = $urandom;
    it.death_rgba       = $urandom;
    return it;
  endfunction

  function automatic void queue_item(in_item_t it);
    if (it.op == OP_SPAWN)
      gen_ptr = (gen_ptr + it.spawn_count) % N_SLOTS;
    pending_items.push_back(it);
  endfunction

  function automatic void queue_random(int n);
    in_item_t it;
    int pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        it = mk_item(OP_SPAWN);
        if ($urandom_range(0, 40) == 0) it.spawn_count = 11'($urandom_range(17, 1100));
        if ($urandom_range(0, 60) == 0) it.life_time = '0;
        if ($urandom_range(0, 20) == 0) it.life_time = 16'($urandom);
      end else if (pick < 45) begin
        it = mk_item(OP_ADVANCE);
        if ($urandom_range(0, 10) == 0) it.time_step = 16'($urandom);
      end else if (pick < 95) begin
        it = mk_item(OP_READ);
        // mostly aim at recently spawned slots
        if ($urandom_range(0, 3) != 0)
          it.slot_index = 10'((gen_ptr + N_SLOTS - 1 - $urandom_range(0, 40)) % N_SLOTS);
      end else begin
        it = mk_item(OP_NOP);
      end
      queue_item(it);
    end
  endfunction

  // Let every queued transaction and result drain, then give the block slack.
  task automatic drain_all();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (30) @(negedge clk);
  endtask

  task automatic load_seed(logic [31:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    p_rng = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    in_item_t it;
    for (int i = 0; i < N_SLOTS; i++) p_live[i] = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    load_seed(32'hFFFF_FFFF);

    // Directed: empty pool, field extremes, bound order, zero lifetime,
    // no-op and an oversize wrapping spawn.
    it = mk_item(OP_READ);    it.slot_index = 10'd0;   queue_item(it);
    it = mk_item(OP_READ);    it.slot_index = 10'd1023; queue_item(it);
    it = mk_item(OP_NOP);     it.slot_index = 10'd0;   queue_item(it);
    it = mk_item(OP_SPAWN);   it.spawn_count = 11'd1; it.life_time = 16'hFFFF;
    it.position_xy = 32'h8000_7FFF; it.velocity_low_xy = 32'h8000_8000;
    it.velocity_high_xy = 32'h7FFF_7FFF; it.size_low_xy = 32'h0;
    it.size_high_xy = 32'hFFFF_FFFF; it.birth_rgba = 32'h0; it.death_rgba = 32'hFFFF_FFFF;
    queue_item(it);
    it = mk_item(OP_SPAWN);   it.spawn_count = 11'd2; it.life_time = 16'd1;
    it.velocity_low_xy = 32'h7FFF_7FFF; it.velocity_high_xy = 32'h8000_8000;
    it.size_low_xy = 32'hFFFF_FFFF; it.size_high_xy = 32'h0;
    it.birth_rgba = 32'hFFFF_FFFF; it.death_rgba = 32'h0; queue_item(it);
    it = mk_item(OP_SPAWN);   it.spawn_count = 11'd1; it.life_time = 16'd0; queue_item(it);
    for (int i = 0; i < 4; i++) begin
      it = mk_item(OP_READ); it.slot_index = 10'(i); queue_item(it);
    end
    it = mk_item(OP_ADVANCE); it.time_step = 16'd0; queue_item(it);
    it = mk_item(OP_READ);    it.slot_index = 10'd0; queue_item(it);
    it = mk_item(OP_ADVANCE); it.time_step = 16'hFFFF; queue_item(it);
    it = mk_item(OP_READ);    it.slot_index = 10'd0; queue_item(it);
    it = mk_item(OP_ADVANCE); it.time_step = 16'hFFFF; queue_item(it);
    it = mk_item(OP_READ);    it.slot_index = 10'd0; queue_item(it);
    it = mk_item(OP_SPAWN);   it.spawn_count = 11'd2047; it.life_time = 16'd5000;
    queue_item(it);
    it = mk_item(OP_READ);    it.slot_index = 10'd1023; queue_item(it);
    it = mk_item(OP_ADVANCE); it.time_step = 16'd4999; queue_item(it);
    it = mk_item(OP_READ);    it.slot_index = 10'd512; queue_item(it);
    it = mk_item(OP_ADVANCE); it.time_step = 16'd1; queue_item(it);
    drain_all();

    // Random phases across several seeds; each drain is a full pause of the sender.
    load_seed(32'd1);
    queue_random(140);
    drain_all();
    load_seed(32'd0);
    queue_random(40);
    drain_all();
    load_seed(SEED_RESET);
    queue_random(80);
    drain_all();
    load_seed($urandom);
    queue_random(170);
    // final stretch runs without idling
    wait (pending_items.size() < 60);
    quiet = 1'b1;
    drain_all();

    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/ppe_pkg.sv
hw/rtl/ppe_ram.sv
hw/rtl/ppe_ctrl.sv
hw/rtl/ppe_datapath.sv
hw/rtl/particle_pool_engine.sv
hw/rtl/ppe_checker.sv
tb/sv/tb_particle_pool_engine.sv
